// ===== hw/rtl/stbs_pkg.sv =====
package stbs_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int KEY_W         = 32;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 3;
  localparam int POS_W         = 10;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_RD_A,
    S_SORT_RD_B,
    S_SORT_CMP,
    S_SORT_WR,
    S_PROBE,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// ===== hw/rtl/stbs_ram.sv =====
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/stbs_cmp.sv =====
module stbs_cmp (
  input  logic [stbs_pkg::KEY_W-1:0] a,
  input  logic [stbs_pkg::KEY_W-1:0] b,
  output stbs_pkg::cmp_res_t         res
);

  import stbs_pkg::*;

  always_comb begin
    res.lt = $signed(a) < $signed(b);
    res.eq = a == b;
  end

endmodule

// ===== hw/rtl/sorted_table_binary_search.sv =====
// Channel  | Direction | Ports                          | Transaction
// in_      | input     | in_valid, in_ready, in_kind,   | clear, append or search
//          |           | in_key                         |
// out_     | output    | out_valid, out_ready,          | one result per kind 0 to 2
//          |           | out_status, out_position       |
//
// Clear and append go straight to the result state; kind 3 is taken and gives no result.
// A search runs each probe through S_PROBE and S_CHECK and uses the shared comparator.
// The first search after appends first runs the gap sort on the two-port key memory:
// each pair is read in RD_A and RD_B and compared in CMP, and a swap adds WR.
// Reset clears the count and marks the table sorted; the keys need no clearing.
// The input is not ready until a result sits in the output register, which holds it
// while out_ready is low.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [stbs_pkg::KIND_W-1:0]    in_kind,
  input  logic signed [stbs_pkg::KEY_W-1:0] in_key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [stbs_pkg::STATUS_W-1:0]  out_status,
  output logic [stbs_pkg::POS_W-1:0]     out_position
);

  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = AW + 1;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic sorted_r, sorted_nxt;
  logic [AW-1:0] gap_r, gap_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic swapped_r, swapped_nxt;
  logic [KEY_W-1:0] a_r, a_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hp_r, hp_nxt;
  logic [AW-1:0] mid_r, mid_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;

  logic accept;
  logic out_load;
  logic full;
  logic [SW-1:0] pair_sum;
  logic [CW:0] mid_sum;
  logic [AW-1:0] mid_calc;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  logic [KEY_W-1:0] cmp_b;
  cmp_res_t cmp_res;

  stbs_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  stbs_cmp u_cmp (
    .a  (ram_rdata),
    .b  (cmp_b),
    .res(cmp_res)
  );

  assign accept   = in_valid && in_ready;
  assign full     = count_r >= CW'(TABLE_DEPTH);
  assign pair_sum = SW'(j_r) + SW'(gap_r);
  assign mid_sum  = (CW + 1)'(lo_r) + (CW + 1)'(hp_r) - (CW + 1)'(1);
  assign mid_calc = AW'(mid_sum >> 1);
  assign cmp_b    = (state_r == S_CHECK) ? key_r : a_r;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    sorted_nxt     = sorted_r;
    gap_nxt        = gap_r;
    j_nxt          = j_r;
    swapped_nxt    = swapped_r;
    a_nxt          = a_r;
    key_nxt        = key_r;
    lo_nxt         = lo_r;
    hp_nxt         = hp_r;
    mid_nxt        = mid_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt     = in_key;
          res_pos_nxt = '0;
          unique case (in_kind)
            KIND_CLEAR: begin
              count_nxt      = '0;
              sorted_nxt     = 1'b1;
              res_status_nxt = ST_CLEARED;
              state_nxt      = S_DONE;
            end
            KIND_APPEND: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                count_nxt      = count_r + CW'(1);
                sorted_nxt     = 1'b0;
                res_status_nxt = ST_APPENDED;
              end
              state_nxt = S_DONE;
            end
            KIND_SEARCH: begin
              lo_nxt = '0;
              hp_nxt = count_r;
              if (sorted_r) begin
                state_nxt = S_PROBE;
              end else begin
                gap_nxt     = AW'(count_r >> 1);
                j_nxt       = '0;
                swapped_nxt = 1'b0;
                state_nxt   = S_SORT_RD_A;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SORT_RD_A: begin
        if (gap_r == '0) begin
          sorted_nxt = 1'b1;
          state_nxt  = S_PROBE;
        end else if (pair_sum >= SW'(count_r)) begin
          j_nxt       = '0;
          swapped_nxt = 1'b0;
          if (!swapped_r) begin
            gap_nxt = gap_r >> 1;
          end
        end else begin
          state_nxt = S_SORT_RD_B;
        end
      end
      S_SORT_RD_B: begin
        a_nxt     = ram_rdata;
        state_nxt = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (cmp_res.lt) begin
          swapped_nxt = 1'b1;
          state_nxt   = S_SORT_WR;
        end else begin
          j_nxt     = j_r + AW'(1);
          state_nxt = S_SORT_RD_A;
        end
      end
      S_SORT_WR: begin
        j_nxt     = j_r + AW'(1);
        state_nxt = S_SORT_RD_A;
      end
      S_PROBE: begin
        if (lo_r < hp_r) begin
          mid_nxt   = mid_calc;
          state_nxt = S_CHECK;
        end else begin
          res_status_nxt = ST_MISSING;
          res_pos_nxt    = '0;
          state_nxt      = S_DONE;
        end
      end
      S_CHECK: begin
        if (cmp_res.eq) begin
          res_status_nxt = ST_FOUND;
          res_pos_nxt    = POS_W'(mid_r);
          state_nxt      = S_DONE;
        end else begin
          if (cmp_res.lt) begin
            lo_nxt = CW'(mid_r) + CW'(1);
          end else begin
            hp_nxt = CW'(mid_r);
          end
          state_nxt = S_PROBE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = j_r;
    ram_wdata = ram_rdata;
    ram_raddr = j_r;
    unique case (state_r)
      S_IDLE: begin
        ram_we    = accept && (in_kind == KIND_APPEND) && !full;
        ram_waddr = AW'(count_r);
        ram_wdata = in_key;
      end
      S_SORT_RD_A: begin
        ram_raddr = j_r;
      end
      S_SORT_RD_B: begin
        ram_raddr = AW'(pair_sum);
      end
      S_SORT_CMP: begin
        ram_we    = cmp_res.lt;
        ram_waddr = j_r;
        ram_wdata = ram_rdata;
      end
      S_SORT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pair_sum);
        ram_wdata = a_r;
      end
      S_PROBE: begin
        ram_raddr = mid_calc;
      end
      S_CHECK: begin
        ram_raddr = mid_r;
      end
      S_DONE: begin
        ram_raddr = j_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_pos_nxt    = res_pos_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sorted_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sorted_r    <= sorted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gap_r        <= gap_nxt;
    j_r          <= j_nxt;
    swapped_r    <= swapped_nxt;
    a_r          <= a_nxt;
    key_r        <= key_nxt;
    lo_r         <= lo_nxt;
    hp_r         <= hp_nxt;
    mid_r        <= mid_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;

endmodule

// ===== tb/sorted_table_binary_search_tb.sv =====
module sorted_table_binary_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  localparam int TB_DEPTH = DEPTH_DEFAULT;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 160;
  localparam int STALL_LIMIT = 500_000;
  localparam int SETTLE_CYCLES = 64;

  typedef enum int {KEYS_WIDE, KEYS_CLUSTERED, KEYS_EDGES} key_mix_t;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
    bit                      drain;
  } table_op_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } lookup_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [KIND_W-1:0]       in_kind = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic [POS_W-1:0]        out_position;

  table_op_t      pending_ops[$];
  lookup_result_t awaited_results[$];

  logic signed [KEY_W-1:0] shadow_keys[TB_DEPTH];
  int unsigned             shadow_count = 0;
  bit                      shadow_sorted = 1'b1;

  table_op_t   cur_op;
  bit          have_item = 1'b0;
  bit          send_burst = 1'b0;
  int unsigned send_hold = 0;
  bit          recv_burst = 1'b0;
  int unsigned recv_hold = 0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;

  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ops_taken = 0;
  int unsigned results_seen = 0;
  int unsigned found_seen = 0;
  int unsigned missing_seen = 0;
  int unsigned full_seen = 0;
  int unsigned largest_table = 0;

  sorted_table_binary_search #(
    .TABLE_DEPTH(TB_DEPTH)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_position(out_position)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit predict_lookup(input logic [KIND_W-1:0] kind,
                                        input logic signed [KEY_W-1:0] key,
                                        output lookup_result_t res);
    int unsigned gap;
    int unsigned j;
    bit swapped;
    logic signed [KEY_W-1:0] tmp;
    int lo;
    int hi;
    int mid;
    res.status = ST_CLEARED;
    res.position = '0;
    case (kind)
      KIND_CLEAR: begin
        shadow_count = 0;
        shadow_sorted = 1'b1;
      end
      KIND_APPEND: begin
        if (shadow_count >= TB_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_keys[shadow_count] = key;
          shadow_count++;
          shadow_sorted = 1'b0;
          res.status = ST_APPENDED;
        end
      end
      KIND_SEARCH: begin
        if (!shadow_sorted) begin
          gap = shadow_count / 2;
          while (gap > 0) begin
            swapped = 1'b1;
            while (swapped) begin
              swapped = 1'b0;
              for (j = 0; j + gap < shadow_count; j++) begin
                if (shadow_keys[j + gap] < shadow_keys[j]) begin
                  tmp = shadow_keys[j];
                  shadow_keys[j] = shadow_keys[j + gap];
                  shadow_keys[j + gap] = tmp;
                  swapped = 1'b1;
                end
              end
            end
            gap = gap / 2;
          end
          shadow_sorted = 1'b1;
        end
        res.status = ST_MISSING;
        lo = 0;
        hi = int'(shadow_count) - 1;
        while (lo <= hi && res.status == ST_MISSING) begin
          mid = (lo + hi) / 2;
          if (shadow_keys[mid] == key) begin
            res.status = ST_FOUND;
            res.position = POS_W'(mid);
          end else if (key > shadow_keys[mid]) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic signed [KEY_W-1:0] draw_key(key_mix_t mix);
    case (mix)
      KEYS_CLUSTERED: return int'($urandom_range(0, 16)) - 8;
      KEYS_EDGES: begin
        case ($urandom_range(0, 5))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return -1;
          3: return 0;
          4: return 1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_op(logic [KIND_W-1:0] kind, logic signed [KEY_W-1:0] key,
                                 bit drain);
    table_op_t op;
    op.kind = kind;
    op.key = key;
    op.drain = drain;
    pending_ops.push_back(op);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  // Driver: one item at a time from the pending queue, with a drawn hold-off before each.
  always @(negedge clk) begin
    logic drive_valid;
    drive_valid = 1'b0;
    if (rst_n) begin
      if (in_valid && in_taken) begin
        have_item = 1'b0;
      end
      if (!have_item && pending_ops.size() > 0 &&
          !(pending_ops[0].drain && awaited_results.size() > 0)) begin
        cur_op = pending_ops.pop_front();
        have_item = 1'b1;
        if ($urandom_range(0, 39) == 0) begin
          send_burst = !send_burst;
        end
        send_hold = send_burst ? 0 : $urandom_range(0, 13);
      end
      if (in_valid && !in_taken) begin
        drive_valid = 1'b1;
      end else if (have_item) begin
        if (send_hold == 0) begin
          drive_valid = 1'b1;
        end else begin
          send_hold--;
        end
      end
    end
    in_valid <= drive_valid;
    if (drive_valid) begin
      in_kind <= cur_op.kind;
      in_key <= cur_op.key;
    end
  end

  // The stall before each result only counts down while a result is on offer.
  always @(negedge clk) begin
    logic ready_next;
    ready_next = 1'b0;
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 29) == 0) begin
          recv_burst = !recv_burst;
        end
        recv_hold = recv_burst ? 0 : $urandom_range(0, 13);
      end else if (out_valid && recv_hold > 0) begin
        recv_hold--;
      end
      ready_next = (recv_hold == 0);
    end
    out_ready <= ready_next;
  end

  always @(posedge clk) begin
    lookup_result_t predicted;
    lookup_result_t want;
    in_taken <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        ops_taken++;
        if (predict_lookup(in_kind, in_key, predicted)) begin
          awaited_results.push_back(predicted);
        end
        if (shadow_count > largest_table) begin
          largest_table = shadow_count;
        end
      end
      if (out_valid && out_ready) begin
        results_seen++;
        case (out_status)
          ST_FOUND:   found_seen++;
          ST_MISSING: missing_seen++;
          ST_FULL:    full_seen++;
          default: ;
        endcase
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("result with none awaited: status %0d position %0d",
                                 out_status, out_position));
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status || out_position !== want.position) begin
            note_failure($sformatf({"result %0d mismatch: status %0d position %0d, ",
                                    "expected status %0d position %0d"}, results_seen,
                                   out_status, out_position, want.status, want.position));
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          !(have_item || pending_ops.size() > 0 || awaited_results.size() > 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("No transaction for %0d cycles, %0d results still awaited.",
                   STALL_LIMIT, awaited_results.size());
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    logic signed [KEY_W-1:0] k;
    logic signed [KEY_W-1:0] phase_keys[$];
    int unsigned random_items;
    int unsigned append_left;
    int unsigned search_left;
    key_mix_t mix;

    // Directed: empty table, unused kind, extreme and duplicate keys, clear.
    add_op(KIND_SEARCH, 0, 1'b0);
    add_op(KIND_UNUSED, 32'sh7FFF_FFFF, 1'b0);
    add_op(KIND_APPEND, 32'sh7FFF_FFFF, 1'b0);
    add_op(KIND_APPEND, 32'sh8000_0000, 1'b0);
    add_op(KIND_APPEND, -1, 1'b0);
    add_op(KIND_APPEND, 0, 1'b0);
    add_op(KIND_APPEND, 1, 1'b0);
    add_op(KIND_APPEND, 5, 1'b0);
    add_op(KIND_APPEND, 5, 1'b0);
    add_op(KIND_SEARCH, 32'sh8000_0000, 1'b0);
    add_op(KIND_SEARCH, 32'sh7FFF_FFFF, 1'b0);
    add_op(KIND_SEARCH, 5, 1'b0);
    add_op(KIND_SEARCH, 3, 1'b0);
    add_op(KIND_SEARCH, -1, 1'b0);
    add_op(KIND_UNUSED, -1, 1'b0);
    add_op(KIND_CLEAR, $urandom, 1'b1);
    add_op(KIND_SEARCH, 5, 1'b0);
    add_op(KIND_APPEND, 5, 1'b0);
    add_op(KIND_SEARCH, 5, 1'b0);
    add_op(KIND_SEARCH, 32'sh7FFF_FFFF, 1'b0);
    add_op(KIND_APPEND, 32'sh5555_5555, 1'b0);
    add_op(KIND_SEARCH, 32'shAAAA_AAAA, 1'b0);
    add_op(KIND_SEARCH, 32'sh5555_5555, 1'b0);

    // Fill the whole table with nearly ascending keys so that the sort stays short.
    add_op(KIND_CLEAR, 0, 1'b1);
    phase_keys.delete();
    for (int i = 0; i < TB_DEPTH; i++) begin
      if (i == 100) begin
        k = 32'sh7FFF_FFFF;
      end else if (i == 900) begin
        k = 32'sh8000_0000;
      end else begin
        k = (i - 512) * 4_000_000 + int'($urandom_range(0, 7_999_999));
      end
      phase_keys.push_back(k);
      add_op(KIND_APPEND, k, 1'b0);
    end
    repeat (20) begin
      add_op(KIND_SEARCH, phase_keys[$urandom_range(0, TB_DEPTH - 1)], 1'b0);
    end
    add_op(KIND_SEARCH, 32'sh8000_0000, 1'b0);
    add_op(KIND_SEARCH, 32'sh7FFF_FFFF, 1'b0);
    add_op(KIND_SEARCH, $urandom, 1'b0);
    add_op(KIND_APPEND, $urandom, 1'b0);
    add_op(KIND_APPEND, 32'sh8000_0000, 1'b0);
    add_op(KIND_SEARCH, phase_keys[0], 1'b0);
    add_op(KIND_SEARCH, phase_keys[TB_DEPTH - 1], 1'b0);
    add_op(KIND_UNUSED, $urandom, 1'b0);
    add_op(KIND_CLEAR, $urandom, 1'b0);
    add_op(KIND_SEARCH, phase_keys[0], 1'b0);

    // Random phases: mostly a clear, a batch of appends and searches interleaved.
    random_items = 0;
    phase_keys.delete();
    while (random_items < RANDOM_ITEMS) begin
      append_left = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160)
                                               : $urandom_range(0, 24);
      search_left = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        2: mix = KEYS_CLUSTERED;
        3: mix = KEYS_EDGES;
        default: mix = KEYS_WIDE;
      endcase
      if (phase_keys.size() > 150 || $urandom_range(0, 7) != 0) begin
        phase_keys.delete();
        add_op(KIND_CLEAR, $urandom, $urandom_range(0, 7) == 0);
        random_items++;
      end
      while (append_left > 0 || search_left > 0) begin
        if ($urandom_range(0, 24) == 0) begin
          add_op(KIND_UNUSED, $urandom, 1'b0);
        end
        if (append_left > 0 && (search_left == 0 || $urandom_range(0, 9) < 7)) begin
          k = draw_key(mix);
          phase_keys.push_back(k);
          add_op(KIND_APPEND, k, 1'b0);
          append_left--;
        end else begin
          if (phase_keys.size() > 0 && $urandom_range(0, 9) < 7) begin
            k = phase_keys[$urandom_range(0, phase_keys.size() - 1)];
          end else if (phase_keys.size() > 0 && $urandom_range(0, 1) == 0) begin
            k = phase_keys[$urandom_range(0, phase_keys.size() - 1)] + 1;
          end else begin
            k = draw_key(mix);
          end
          add_op(KIND_SEARCH, k, 1'b0);
          search_left--;
        end
        random_items++;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || have_item || in_valid || awaited_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Accepted %0d transactions and checked %0d results: %0d found, %0d not found,",
             ops_taken, results_seen, found_seen, missing_seen);
    $display("%0d dropped on a full table; largest table held %0d keys.",
             full_seen, largest_table);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
